### design/square_matrix_multiply_top_assert.svh
// Assertion macros for the matrix multiplier.
// SMM_ASSERT_IMPL checks a same-cycle implication, SMM_ASSERT_NEXT a next-cycle one.
`ifndef SQUARE_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SMM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/smm_pkg.sv
package smm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int ELEM_WIDTH  = 32;
    localparam int FRAC_BITS   = ELEM_WIDTH / 2;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int COUNT_W     = 7;
    localparam int PROD_W      = 2 * ELEM_WIDTH;
    localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int MAG_W       = ACC_W - FRAC_BITS;
    localparam int LIM_W       = ELEM_WIDTH + 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // One product job: the dimension latched at the end of a load round
    typedef struct packed {
        logic [DIM_W-1:0] n;
    } job_t;

    // Store write from the front to the back
    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [ELEM_WIDTH-1:0] a;
        logic [ELEM_WIDTH-1:0] b;
    } wr_t;

    // Clamp the dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

### design/smm_if.sv
interface smm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smm_pkg::ELEM_WIDTH-1:0] a_elem;
    logic signed [smm_pkg::ELEM_WIDTH-1:0] b_elem;

    modport source (output valid, output a_elem, output b_elem, input ready);
    modport sink   (input valid, input a_elem, input b_elem, output ready);
endinterface

interface smm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smm_pkg::ELEM_WIDTH-1:0] product;
    logic [smm_pkg::IDX_W-1:0]             row;
    logic [smm_pkg::IDX_W-1:0]             col;
    logic                                  saturated;
    logic                                  last;

    modport source (output valid, output product, output row, output col,
                    output saturated, output last, input ready);
    modport sink   (input valid, input product, input row, input col,
                    input saturated, input last, output ready);
endinterface

### design/smm_front.sv
`include "square_matrix_multiply_top_assert.svh"

module smm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [smm_pkg::DIM_W-1:0]     cfg_data,
    smm_in_if.sink                        in_item,
    input  logic                          hold,
    output smm_pkg::wr_t                  wr,
    output logic                          push,
    output smm_pkg::job_t                 job
);

    logic [smm_pkg::DIM_W-1:0]   dim_reg;
    logic [smm_pkg::COUNT_W-1:0] load_count_reg;
    logic [smm_pkg::COUNT_W-1:0] load_count_next;
    logic [smm_pkg::COUNT_W-1:0] count_inc;
    logic [smm_pkg::COUNT_W-1:0] total;
    logic [smm_pkg::DIM_W-1:0]   n;
    logic                        accept;
    logic                        done;

    // Stall intake while a product is queued or being computed
    assign in_item.ready = !hold;
    assign accept        = in_item.valid && in_item.ready;

    assign n         = smm_pkg::eff_dim(dim_reg);
    assign total     = smm_pkg::COUNT_W'(n) * smm_pkg::COUNT_W'(n);
    assign count_inc = load_count_reg + smm_pkg::COUNT_W'(1);
    assign done      = count_inc >= total;

    // Write the item into the stores
    always_comb
    begin
        wr.en   = accept && (load_count_reg < smm_pkg::COUNT_W'(smm_pkg::STORE_DEPTH));
        wr.addr = load_count_reg[smm_pkg::ADDR_W-1:0];
        wr.a    = in_item.a_elem;
        wr.b    = in_item.b_elem;
    end

    // Hand a job to the back once a full round is loaded
    assign push  = accept && done;
    assign job.n = n;

    always_comb
    begin
        load_count_next = load_count_reg;
        if (accept)
        begin
            load_count_next = done ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg        <= smm_pkg::DIM_RESET;
            load_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dim_reg <= cfg_data;
            end
            load_count_reg <= load_count_next;
        end
    end

    `SMM_ASSERT_IMPL(a_count_in_store, clk, rst_n, accept,
                     load_count_reg < smm_pkg::COUNT_W'(smm_pkg::STORE_DEPTH))

endmodule

### design/smm_queue.sv
`include "square_matrix_multiply_top_assert.svh"

module smm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  smm_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output smm_pkg::job_t pop_data,
    output logic          empty
);

    smm_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    `SMM_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)

endmodule

### design/smm_back.sv
`include "square_matrix_multiply_top_assert.svh"

module smm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  smm_pkg::wr_t  wr,
    input  logic          job_valid,
    input  smm_pkg::job_t job,
    output logic          pop,
    output logic          busy,
    smm_out_if.source     out_item
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ABS   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam int EW = smm_pkg::ELEM_WIDTH;
    localparam int AW = smm_pkg::ADDR_W;
    localparam int IW = smm_pkg::IDX_W;
    localparam int DW = smm_pkg::DIM_W;

    logic [EW-1:0] left_mem  [smm_pkg::STORE_DEPTH];
    logic [EW-1:0] right_mem [smm_pkg::STORE_DEPTH];

    logic [2:0]    state_reg, state_next;
    logic [DW-1:0] n_reg, n_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] c_reg, c_next;
    logic [IW-1:0] k_reg, k_next;
    logic [AW-1:0] a_addr_reg, a_addr_next;
    logic [AW-1:0] b_addr_reg, b_addr_next;
    logic [AW-1:0] a_base_reg, a_base_next;
    logic          acc_clr;

    logic                                  rd_vld_reg;
    logic                                  mul_vld_reg;
    logic signed [EW-1:0]                  a_rd_reg;
    logic signed [EW-1:0]                  b_rd_reg;
    logic signed [smm_pkg::PROD_W-1:0]     prod_reg;
    logic signed [smm_pkg::ACC_W-1:0]      acc_reg;
    logic [smm_pkg::ACC_W-1:0]             mag_reg;
    logic                                  neg_reg;

    logic                                  out_valid_reg;
    logic [EW-1:0]                         product_reg;
    logic [IW-1:0]                         row_reg;
    logic [IW-1:0]                         col_reg;
    logic                                  sat_reg;
    logic                                  last_reg;

    logic [smm_pkg::MAG_W-1:0] shifted;
    logic [smm_pkg::LIM_W-1:0] lim;
    logic                      sat;
    logic [EW-1:0]             clipped;
    logic [EW-1:0]             result;
    logic [IW-1:0]             n_last;
    logic                      elem_last;
    logic                      slot_free;
    logic                      load_out;

    // Operand stores: written by the front, read by the MAC loop
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            left_mem[wr.addr]  <= wr.a;
            right_mem[wr.addr] <= wr.b;
        end
        a_rd_reg <= left_mem[a_addr_reg];
        b_rd_reg <= right_mem[b_addr_reg];
    end

    // Multiply stage, accumulate stage and the magnitude register
    always_ff @(posedge clk)
    begin
        prod_reg <= a_rd_reg * b_rd_reg;
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + smm_pkg::ACC_W'(prod_reg);
        end
        if (state_reg == S_ABS)
        begin
            neg_reg <= acc_reg[smm_pkg::ACC_W-1];
            mag_reg <= acc_reg[smm_pkg::ACC_W-1] ? smm_pkg::ACC_W'(-acc_reg)
                                                 : smm_pkg::ACC_W'(acc_reg);
        end
    end

    // Truncate toward zero and saturate
    always_comb
    begin
        shifted = mag_reg[smm_pkg::ACC_W-1:smm_pkg::FRAC_BITS];
        lim     = (smm_pkg::LIM_W'(1) << (EW - 1)) - (neg_reg ? '0 : smm_pkg::LIM_W'(1));
        sat     = shifted > smm_pkg::MAG_W'(lim);
        clipped = sat ? lim[EW-1:0] : shifted[EW-1:0];
        result  = neg_reg ? (~clipped + EW'(1)) : clipped;
    end

    assign n_last    = IW'(n_reg - DW'(1));
    assign elem_last = (r_reg == n_last) && (c_reg == n_last);
    assign slot_free = !out_valid_reg || out_item.ready;
    assign load_out  = (state_reg == S_FIN) && slot_free;

    // Sequence rows, columns and the inner dot-product index
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        a_base_next = a_base_reg;
        acc_clr     = 1'b0;
        pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop         = 1'b1;
                    n_next      = job.n;
                    r_next      = '0;
                    c_next      = '0;
                    k_next      = '0;
                    a_addr_next = '0;
                    b_addr_next = '0;
                    a_base_next = '0;
                    acc_clr     = 1'b1;
                    state_next  = S_MAC;
                end
            end
            S_MAC:
            begin
                a_addr_next = a_addr_reg + AW'(1);
                b_addr_next = b_addr_reg + AW'(n_reg);
                k_next      = k_reg + IW'(1);
                if (k_reg == n_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    if (elem_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next  = '0;
                        acc_clr = 1'b1;
                        if (c_reg == n_last)
                        begin
                            c_next      = '0;
                            r_next      = r_reg + IW'(1);
                            a_base_next = a_base_reg + AW'(n_reg);
                            a_addr_next = a_base_reg + AW'(n_reg);
                            b_addr_next = '0;
                        end
                        else
                        begin
                            c_next      = c_reg + IW'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = AW'(c_reg) + AW'(1);
                        end
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            n_reg       <= smm_pkg::DIM_RESET;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            a_addr_reg  <= '0;
            b_addr_reg  <= '0;
            a_base_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            a_addr_reg  <= a_addr_next;
            b_addr_reg  <= b_addr_next;
            a_base_reg  <= a_base_next;
            rd_vld_reg  <= state_reg == S_MAC;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    // Output register: hold until taken, reload when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            product_reg <= result;
            row_reg     <= r_reg;
            col_reg     <= c_reg;
            sat_reg     <= sat;
            last_reg    <= elem_last;
        end
    end

    assign busy               = state_reg != S_IDLE;
    assign out_item.valid     = out_valid_reg;
    assign out_item.product   = product_reg;
    assign out_item.row       = row_reg;
    assign out_item.col       = col_reg;
    assign out_item.saturated = sat_reg;
    assign out_item.last      = last_reg;

    `SMM_ASSERT_NEXT(a_mac_pipe, clk, rst_n, rd_vld_reg, mul_vld_reg)
    `SMM_ASSERT_IMPL(a_abs_drained, clk, rst_n, state_reg == S_ABS,
                     !rd_vld_reg && !mul_vld_reg)
    `SMM_ASSERT_IMPL(a_last_diag, clk, rst_n, out_valid_reg && last_reg,
                     row_reg == col_reg)

endmodule

### design/square_matrix_multiply_top.sv
// Square matrix multiplier, signed Q16.16, dimension 1 to 8.
// Input channel in_item: each item carries a_elem and b_elem, one element of A
// and of B at the same position, row-major. Output channel out_item: one item
// per product element, row-major, with row, col, a saturation flag and last
// on the final element. Both channels use valid/ready.
// cfg_we/cfg_data write the dimension register (reset 8; 0 acts as 1, above 8
// as 8). Write it only while the block is idle.
// Loading accepts one item per cycle. After the n*n-th item the intake stalls
// while the product is computed: each element takes n multiply-accumulates
// through one multiplier reading both stores, a drain of the read, multiply
// and accumulate stages, a magnitude step and a truncate-and-saturate step.
// A stalled receiver holds the output register and freezes the compute loop
// once the next element is ready; nothing is dropped.
// Reset clears the load count, the job queue and the sequencer; the stores
// need no clearing.
`include "square_matrix_multiply_top_assert.svh"

module square_matrix_multiply_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [smm_pkg::DIM_W-1:0] cfg_data,
    smm_in_if.sink                    in_item,
    smm_out_if.source                 out_item
);

    smm_pkg::wr_t  wr;
    smm_pkg::job_t push_job;
    smm_pkg::job_t pop_job;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          busy;
    logic          hold;

    // Stall intake while a product is pending or running
    assign hold = !q_empty || busy;

    smm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_item  (in_item),
        .hold     (hold),
        .wr       (wr),
        .push     (push),
        .job      (push_job)
    );

    smm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (q_empty)
    );

    smm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .job_valid (!q_empty),
        .job       (pop_job),
        .pop       (pop),
        .busy      (busy),
        .out_item  (out_item)
    );

    `SMM_ASSERT_IMPL(a_hold_when_full, clk, rst_n, q_full, !in_item.ready)

endmodule
